@@ rtl/tivt_pkg.sv @@
// shared types and constants for the track identity vote table
// no dependencies; imported by every module of the block
package tivt_pkg;

  // field widths
  localparam int TRACK_W = 6;
  localparam int NAME_W  = 4;
  localparam int SCORE_W = 8;

  // table geometry follows the field widths
  localparam int TRACKS = 1 << TRACK_W;
  localparam int NAMES  = 1 << NAME_W;

  // argmax tree: first level scans groups of GRP names
  localparam int GRP  = 4;
  localparam int NGRP = NAMES / GRP;

  // command codes
  localparam logic CMD_OBSERVE = 1'b0;
  localparam logic CMD_REMOVE  = 1'b1;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_SCORE_LIMIT = 1'b0;
  localparam logic [SCORE_W-1:0] LIMIT_RST = 8'd255;

  typedef struct packed {
    logic              command;
    logic [TRACK_W-1:0] track_id;
    logic [NAME_W-1:0]  name_index;
  } in_beat_t;

  typedef struct packed {
    logic [TRACK_W-1:0] track_id_out;
    logic [NAME_W-1:0]  best_name;
    logic [SCORE_W-1:0] best_score;
    logic               found;
  } out_beat_t;

  // one track row of the table
  typedef struct packed {
    logic [NAMES-1:0]              pres;
    logic [NAMES-1:0][SCORE_W-1:0] score;
  } row_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic upd;
    logic arg;
    logic ld_out;
  } dp_cmd_t;

endpackage

@@ rtl/track_identity_vote_table.sv @@
// top level of the track identity vote table: config register and the
// controller/datapath pair; depends on tivt_pkg, tivt_ctrl, tivt_dp
//
// Usage:
//   in channel (in_valid, in_stall, in_beat): one command beat per item.
//     Observe votes name_index on track_id and yields one result beat;
//     remove clears the track's row and yields nothing.
//   out channel (out_valid, out_stall, out_beat): best name, its score and
//     found for the observed track.
//   config port (APB style, cfg_ ports): score_limit at byte address 0,
//     8 bits used; write only while the block is idle. pready is tied high.
// Sequence: an observe reads its row on accept, then updates and writes it
//   back, runs the first argmax level, then the final level with the load,
//   which waits while a held result is stalled; the next beat is taken once
//   the block is idle. The single-port row memory and the two-level argmax
//   tree set this. A remove leaves it idle. One item is in work at a time.
// Reset: all rows read as empty, the limit returns to 255, no result pending.
// Stall: a result waits in the output register while out_stall is high;
//   commands are still taken until the next observe's result waits behind it.
module track_identity_vote_table
  import tivt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_beat_t          in_beat,
  output logic              out_valid,
  input  logic              out_stall,
  output out_beat_t         out_beat,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [SCORE_W-1:0] limit_r;
  logic               wr_en;
  dp_cmd_t            cmd;

  // config register
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (wr_en && cfg_paddr[2] == REG_SCORE_LIMIT) begin
      limit_r <= cfg_pwdata[SCORE_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_SCORE_LIMIT) ?
                      {{(APB_DW-SCORE_W){1'b0}}, limit_r} : '0;

  tivt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_beat.command),
    .in_stall   (in_stall),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .cmd        (cmd)
  );

  tivt_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_beat     (in_beat),
    .score_limit (limit_r),
    .out_beat    (out_beat)
  );

endmodule

@@ rtl/tivt_ctrl.sv @@
// sequencer for the vote table: accept, update, argmax, result hand-off
// depends on tivt_pkg
module tivt_ctrl
  import tivt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_command,
  output logic    in_stall,
  input  logic    out_stall,
  output logic    out_valid,
  output dp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_ARG  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       acc;
  logic       slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign acc       = in_valid & ~in_stall;
  assign slot_free = ~out_valid_r | ~out_stall;

  // datapath commands
  assign cmd.accept = acc;
  assign cmd.upd    = (state_r == S_UPD);
  assign cmd.arg    = (state_r == S_ARG);
  assign cmd.ld_out = (state_r == S_OUT) & slot_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc && in_command == CMD_OBSERVE) state_nxt = S_UPD;
      end
      S_UPD:  state_nxt = S_ARG;
      S_ARG:  state_nxt = S_OUT;
      S_OUT: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result beat valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.ld_out) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/tivt_dp.sv @@
// datapath: row memory, row valid flags, vote update, argmax tree, result register
// depends on tivt_pkg; driven by tivt_ctrl commands
module tivt_dp
  import tivt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  in_beat_t           in_beat,
  input  logic [SCORE_W-1:0] score_limit,
  output out_beat_t          out_beat
);

  row_t               mem [TRACKS];
  logic [TRACKS-1:0]  row_vld_r;
  row_t               rd_row_r;
  logic               rd_vld_r;
  logic [TRACK_W-1:0] trk_r;
  logic [NAME_W-1:0]  nm_r;
  row_t               new_row;
  logic [NAMES-1:0][SCORE_W-1:0] eff_r;
  logic [SCORE_W-1:0] grp_score_r [NGRP];
  logic [NAME_W-1:0]  grp_idx_r   [NGRP];
  logic [SCORE_W-1:0] fin_score;
  logic [NAME_W-1:0]  fin_idx;
  out_beat_t          out_r;

  // capture the command and read its row
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      trk_r    <= in_beat.track_id;
      nm_r     <= in_beat.name_index;
      rd_row_r <= mem[in_beat.track_id];
      rd_vld_r <= row_vld_r[in_beat.track_id];
    end
  end

  // row write-back
  always_ff @(posedge clk) begin
    if (cmd.upd) mem[trk_r] <= new_row;
  end

  // row valid flags: an invalid row reads as all absent
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (cmd.accept && in_beat.command == CMD_REMOVE) begin
      row_vld_r[in_beat.track_id] <= 1'b0;
    end else if (cmd.upd) begin
      row_vld_r[trk_r] <= 1'b1;
    end
  end

  // vote update on one entry, saturation zeroes the rivals
  always_comb begin
    logic [SCORE_W-1:0] sn;
    logic [SCORE_W:0]   inc;
    new_row = rd_row_r;
    if (!rd_vld_r) new_row.pres = '0;
    sn  = new_row.score[nm_r];
    inc = {1'b0, sn} + 1'b1;
    if (!new_row.pres[nm_r]) begin
      new_row.pres[nm_r]  = 1'b1;
      new_row.score[nm_r] = SCORE_W'(1);
    end else if (sn != '0) begin
      if (inc >= {1'b0, score_limit}) begin
        new_row.score       = '0;
        new_row.score[nm_r] = score_limit;
      end else begin
        new_row.score[nm_r] = inc[SCORE_W-1:0];
      end
    end
  end

  // effective scores, absent entries count as zero
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      for (int k = 0; k < NAMES; k++)
        eff_r[k] <= new_row.pres[k] ? new_row.score[k] : '0;
    end
  end

  // first tree level: best of each group, strict compare keeps the lower index
  always_ff @(posedge clk) begin
    if (cmd.arg) begin
      for (int g = 0; g < NGRP; g++) begin
        logic [SCORE_W-1:0] bs;
        logic [NAME_W-1:0]  bi;
        bs = '0;
        bi = '0;
        for (int k = 0; k < GRP; k++) begin
          if (eff_r[g*GRP + k] > bs) begin
            bs = eff_r[g*GRP + k];
            bi = NAME_W'(g*GRP + k);
          end
        end
        grp_score_r[g] <= bs;
        grp_idx_r[g]   <= bi;
      end
    end
  end

  // second tree level
  always_comb begin
    fin_score = '0;
    fin_idx   = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (grp_score_r[g] > fin_score) begin
        fin_score = grp_score_r[g];
        fin_idx   = grp_idx_r[g];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_r.track_id_out <= trk_r;
      out_r.best_name    <= fin_idx;
      out_r.best_score   <= fin_score;
      out_r.found        <= (fin_score != '0);
    end
  end

  assign out_beat = out_r;

endmodule

@@ rtl/tivt_checker.sv @@
// port-level checks for the track identity vote table, bound to the top level
// depends on tivt_pkg
module tivt_checker
  import tivt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input in_beat_t          in_beat,
  input logic              out_valid,
  input logic              out_stall,
  input out_beat_t         out_beat
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("result beat changed while stalled");

  // found agrees with the score, empty result reports name zero
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beat.found == (out_beat.best_score != '0)) &&
                  (out_beat.found || out_beat.best_name == '0))
    else $error("found flag inconsistent with best score");

  // remove returns the block to idle in the cycle after its accept
  a_remove: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_beat.command == CMD_REMOVE |=> !in_stall)
    else $error("remove did not return to idle");

  // observe occupies the block
  a_observe: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_beat.command == CMD_OBSERVE |=> in_stall)
    else $error("observe accepted without occupying the block");

  // reset empties the result channel
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat pending after reset");

endmodule

bind track_identity_vote_table tivt_checker u_tivt_checker (.*);

@@ tb/track_identity_vote_table_checker.sv @@
`timescale 1ns / 100ps
// result checker for the track identity vote table: keeps a mirror of the
// vote rows and the score limit, predicts each observe result and compares
// it with the out channel; depends on tivt_pkg
module track_identity_vote_table_checker
  import tivt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_beat_t          in_beat,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_beat_t         out_beat,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                mismatches,
  output int                outstanding,
  output int                results_checked
);

  localparam int REPORT_MAX = 10;

  // mirror of the vote table and the limit register
  logic [NAMES-1:0]   pres_tab [TRACKS];
  logic [SCORE_W-1:0] score_tab [TRACKS][NAMES];
  logic [SCORE_W-1:0] limit_q;

  // results predicted but not yet seen on the out channel
  out_beat_t best_pending [$];

  int fail_cnt  = 0;
  int check_cnt = 0;

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    results_checked = 0;
  end

  // apply one observe to the mirror and work out the best identity
  function automatic out_beat_t tally_vote(in_beat_t b);
    out_beat_t          res;
    logic [SCORE_W:0]   bumped;
    logic [TRACK_W-1:0] t;
    logic [NAME_W-1:0]  n;
    t = b.track_id;
    n = b.name_index;
    if (!pres_tab[t][n]) begin
      // first vote for this name, no saturation check
      pres_tab[t][n] = 1'b1;
      score_tab[t][n] = SCORE_W'(1);
    end else if (score_tab[t][n] != '0) begin
      bumped = {1'b0, score_tab[t][n]} + 1'b1;
      if (bumped >= {1'b0, limit_q}) begin
        // saturated: winner takes the limit, rivals drop to zero
        for (int k = 0; k < NAMES; k++) score_tab[t][k] = '0;
        score_tab[t][n] = limit_q;
      end else begin
        score_tab[t][n] = bumped[SCORE_W-1:0];
      end
    end
    // strict compare, ties keep the lower index
    res = '0;
    res.track_id_out = t;
    for (int k = 0; k < NAMES; k++) begin
      if (pres_tab[t][k] && score_tab[t][k] > res.best_score) begin
        res.best_score = score_tab[t][k];
        res.best_name  = NAME_W'(k);
      end
    end
    res.found = (res.best_score != '0);
    return res;
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      for (int t = 0; t < TRACKS; t++) begin
        pres_tab[t] = '0;
        for (int k = 0; k < NAMES; k++) score_tab[t][k] = '0;
      end
      limit_q = LIMIT_RST;
      best_pending.delete();
    end else begin
      // register write on the config port
      if (psel && penable && pwrite && pready && (paddr >> 2) == REG_SCORE_LIMIT)
        limit_q = pwdata[SCORE_W-1:0];

      // command beat accepted
      if (in_valid && !in_stall) begin
        if (in_beat.command == CMD_REMOVE) begin
          pres_tab[in_beat.track_id] = '0;
          for (int k = 0; k < NAMES; k++) score_tab[in_beat.track_id][k] = '0;
        end else begin
          best_pending.insert(best_pending.size(), tally_vote(in_beat));
        end
      end

      // result beat accepted
      if (out_valid && !out_stall) begin
        if (best_pending.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX)
            $display("unexpected result beat: track %0d name %0d score %0d found %0b",
                     out_beat.track_id_out, out_beat.best_name,
                     out_beat.best_score, out_beat.found);
        end else begin
          want = best_pending.pop_front();
          check_cnt++;
          if (out_beat.track_id_out !== want.track_id_out ||
              out_beat.best_name !== want.best_name ||
              out_beat.best_score !== want.best_score ||
              out_beat.found !== want.found) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_MAX)
              $display("mismatch: expected track %0d name %0d score %0d found %0b, %s %0d %0d %0d %0b",
                       want.track_id_out, want.best_name, want.best_score, want.found,
                       "got", out_beat.track_id_out, out_beat.best_name,
                       out_beat.best_score, out_beat.found);
          end
        end
      end
    end
    mismatches      <= fail_cnt;
    outstanding     <= best_pending.size();
    results_checked <= check_cnt;
  end

endmodule

@@ tb/track_identity_vote_table_test.sv @@
`timescale 1ns / 100ps
// top of the track identity vote table testbench: clock, reset, command and
// config stimulus, receiver stalls and the verdict; depends on tivt_pkg,
// track_identity_vote_table and track_identity_vote_table_checker
module track_identity_vote_table_test;
  import tivt_pkg::*;

  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 12;
  localparam int TAIL_CYCLES    = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SEG_ITEMS      = 61;
  localparam int REG_UNUSED     = 1;
  localparam logic [APB_AW-1:0] LIMIT_ADDR  = APB_AW'(4 * REG_SCORE_LIMIT);
  localparam logic [APB_AW-1:0] UNUSED_ADDR = APB_AW'(4 * REG_UNUSED);

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  in_beat_t          in_beat   = '0;
  logic              out_stall = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [APB_AW-1:0] paddr     = '0;
  logic [APB_DW-1:0] pwdata    = '0;
  logic              in_stall;
  logic              out_valid;
  out_beat_t         out_beat;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int mismatches;
  int outstanding;
  int results_checked;

  // idle rates in percent, receiver hold-off requests
  int tx_pct     = 0;
  int rx_pct     = 0;
  int hold_req   = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int quiet      = 0;
  int items_sent = 0;
  int limit_sets = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  track_identity_vote_table uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_beat     (in_beat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_beat    (out_beat),
    .cfg_psel    (psel),
    .cfg_penable (penable),
    .cfg_pwrite  (pwrite),
    .cfg_paddr   (paddr),
    .cfg_pwdata  (pwdata),
    .cfg_prdata  (prdata),
    .cfg_pready  (pready)
  );

  track_identity_vote_table_checker score_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_beat         (in_beat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_beat        (out_beat),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("no beat moved for %0d cycles", quiet);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // offer one command beat, with random idle cycles ahead of it
  task automatic offer(input in_beat_t b);
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
  endtask

  task automatic offer_cmd(input logic cmd, input int trk, input int name);
    in_beat_t b;
    b.command    = cmd;
    b.track_id   = TRACK_W'(trk);
    b.name_index = NAME_W'(name);
    offer(b);
  endtask

  // wait for every predicted result to come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // register write while the block is idle: setup then access cycle
  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == LIMIT_ADDR) limit_sets++;
  endtask

  // limit value with random upper bits; small limits reach saturation
  function automatic logic [APB_DW-1:0] pick_limit();
    logic [APB_DW-1:0] data;
    logic [SCORE_W-1:0] lim;
    data = $urandom;
    case ($urandom_range(9))
      0:       lim = '0;
      1:       lim = SCORE_W'(1);
      2:       lim = '1;
      3:       lim = SCORE_W'($urandom_range(255));
      default: lim = SCORE_W'($urandom_range(8, 2));
    endcase
    data[SCORE_W-1:0] = lim;
    return data;
  endfunction

  // mostly votes on a few hot tracks and names, some removes and noise
  function automatic in_beat_t pick_item(input int base);
    in_beat_t b;
    if ($urandom_range(99) < 10) begin
      b = in_beat_t'($urandom);
    end else begin
      b.command    = ($urandom_range(99) < 8) ? CMD_REMOVE : CMD_OBSERVE;
      b.track_id   = TRACK_W'(base + $urandom_range(3));
      b.name_index = ($urandom_range(99) < 75) ? NAME_W'($urandom_range(2))
                                               : NAME_W'($urandom_range(NAMES - 1));
    end
    return b;
  endfunction

  initial begin
    int base;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit: first votes, tie to the lower name, remove and revote
    offer_cmd(CMD_OBSERVE, 0, 0);
    offer_cmd(CMD_OBSERVE, 0, NAMES - 1);
    offer_cmd(CMD_OBSERVE, TRACKS - 1, NAMES - 1);
    offer_cmd(CMD_OBSERVE, TRACKS - 1, NAMES - 1);
    offer_cmd(CMD_REMOVE, TRACKS - 1, NAMES - 1);
    offer_cmd(CMD_OBSERVE, TRACKS - 1, 0);
    offer_cmd(CMD_OBSERVE, 0, NAMES - 1);

    // saturation zeroes the rival, beaten rival stays stuck at zero
    write_reg(LIMIT_ADDR, 32'd3);
    offer_cmd(CMD_OBSERVE, 5, 7);
    offer_cmd(CMD_OBSERVE, 5, 2);
    offer_cmd(CMD_OBSERVE, 5, 7);
    offer_cmd(CMD_OBSERVE, 5, 7);
    offer_cmd(CMD_OBSERVE, 5, 2);
    offer_cmd(CMD_OBSERVE, 5, 7);
    offer_cmd(CMD_REMOVE, 5, 0);

    // limit lowered to the level of a held score
    write_reg(LIMIT_ADDR, 32'd2);
    offer_cmd(CMD_OBSERVE, 0, NAMES - 1);
    offer_cmd(CMD_OBSERVE, 0, 0);

    // limit zero, written with junk in the upper bits
    write_reg(LIMIT_ADDR, 32'hFFFF_FF00);
    offer_cmd(CMD_OBSERVE, 9, 4);
    offer_cmd(CMD_OBSERVE, 9, 4);
    offer_cmd(CMD_OBSERVE, 9, 3);

    // write to an unused register index leaves the limit alone
    write_reg(UNUSED_ADDR, 32'd5);
    offer_cmd(CMD_OBSERVE, 9, 3);

    // limit one
    write_reg(LIMIT_ADDR, 32'd1);
    offer_cmd(CMD_OBSERVE, 10, 1);
    offer_cmd(CMD_OBSERVE, 10, 1);

    // random part: three idle profiles, three limit settings in each
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin tx_pct = 26; rx_pct <= 81; end
        1: begin tx_pct = 81; rx_pct <= 26; end
        default: begin tx_pct = 0; rx_pct <= 0; end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        write_reg(LIMIT_ADDR, pick_limit());
        base = $urandom_range(TRACKS - 4);
        for (int i = 0; i < SEG_ITEMS; i++) begin
          // long receiver hold-off while commands keep coming
          if (seg == 1 && i == 10) hold_req <= hold_req + 1;
          offer(pick_item(base));
        end
      end
    end
    write_reg(LIMIT_ADDR, 32'd255);
    offer_cmd(CMD_OBSERVE, TRACKS - 1, NAMES - 1);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d commands over %0d limit settings, checked %0d result beats",
             items_sent, limit_sets, results_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d failures, %0d results outstanding", mismatches, outstanding);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
